// ===== sv/wspr_enc_pkg.sv =====
package wspr_enc_pkg;

    localparam int SYMBOL_COUNT = 162;
    localparam int MSG_BITS     = 50;
    localparam int CALL_W       = 28;
    localparam int GRID_W       = 22;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 32;
    localparam int GIDX_W       = 5;
    localparam int SYMS_W       = 16;
    localparam int VCNT_W       = 4;
    localparam int SYM_SLOTS    = SYMS_W / 2;

    localparam logic [31:0] POLY_A = 32'hf2d05351;
    localparam logic [31:0] POLY_B = 32'he4613c47;

    // Sync vector, position 0 is the leftmost digit
    localparam logic [0:SYMBOL_COUNT-1] SYNC_VEC = {
        21'b110000001000111000100,
        21'b101111000000010010100,
        21'b000010110011010001101,
        21'b000011010101010010010,
        21'b110001101010001000001,
        21'b001001110110011010001,
        21'b110000010100110000000,
        15'b110101100011000
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENCODE,
        ST_EMIT
    } enc_state_t;

    typedef struct packed {
        logic load;        // take a new message
        logic step;        // one interleave step
        logic start_emit;  // set up group readout
        logic emit;        // push one group to the output register
    } dp_cmd_t;

    typedef struct packed {
        logic enc_done;
        logic last_pending;
        logic out_free;
    } dp_stat_t;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

endpackage

// ===== sv/wspr_symbol_encoder.sv =====
// After a message is accepted, the interleave walk runs, group readout is set up, and group
//   words follow, one group word per cycle while m_tready stays high.
// Messages are handled one at a time; most of the work is the interleave walk over 255
//   bit-reversed indices (one index per cycle). The next message is taken
//   while the last group word still waits in the output register.
// Reset: rst_n asynchronous, active low; clears the controller and output valid.
module wspr_symbol_encoder
    import wspr_enc_pkg::*;
#(
    parameter int SYMBOLS_PER_GROUP = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // call_field[27:0], grid_power_field[49:28]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // group_index[4:0], symbols[20:5],
                                              // valid_count[24:21]
    output logic                   m_tlast    // last_group
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    wspr_enc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wspr_enc_dp #(
        .SYMBOLS_PER_GROUP (SYMBOLS_PER_GROUP)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== sv/wspr_enc_ctrl.sv =====
module wspr_enc_ctrl
    import wspr_enc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    enc_state_t state_reg;
    enc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ENCODE;
                end
            end
            ST_ENCODE:
            begin
                if (stat.enc_done)
                begin
                    cmd.start_emit = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_pending)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/wspr_enc_dp.sv =====
module wspr_enc_dp
    import wspr_enc_pkg::*;
#(
    parameter int SYMBOLS_PER_GROUP = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat
);

    localparam int GROUPS = (SYMBOL_COUNT + SYMBOLS_PER_GROUP - 1) / SYMBOLS_PER_GROUP;
    localparam int GCW    = $clog2(GROUPS + 1);
    localparam int SLOTS  = (SYMBOLS_PER_GROUP < SYM_SLOTS) ? SYMBOLS_PER_GROUP : SYM_SLOTS;

    logic [MSG_BITS-1:0]     msg_reg,   msg_next;
    logic [31:0]             sreg_reg,  sreg_next;
    logic [7:0]              j_reg,     j_next;
    logic [7:0]              i_reg,     i_next;
    logic [SYMBOL_COUNT-1:0] data_reg,  data_next;
    logic [SYMBOL_COUNT-1:0] sync_reg,  sync_next;
    logic [7:0]              rem_reg,   rem_next;
    logic [GCW-1:0]          gcnt_reg,  gcnt_next;
    logic                    ovld_reg,  ovld_next;
    logic [OUT_TDATA_W-1:0]  odata_reg, odata_next;
    logic                    olast_reg, olast_next;

    logic [7:0]        rev;
    logic              hit;
    logic [31:0]       shifted;
    logic              par_bit;
    logic [7:0]        cnt;
    logic [SYMS_W-1:0] syms;

    assign rev     = rev8(j_reg);
    assign hit     = rev < 8'(SYMBOL_COUNT);
    assign shifted = {sreg_reg[30:0], msg_reg[MSG_BITS-1]};
    // even parity index shifts in the next message bit, odd one reuses it
    assign par_bit = i_reg[0] ? ^(sreg_reg & POLY_B) : ^(shifted & POLY_A);

    assign cnt = (rem_reg < 8'(SYMBOLS_PER_GROUP)) ? rem_reg : 8'(SYMBOLS_PER_GROUP);

    always_comb
    begin
        syms = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            syms[2*k +: 2] = {data_reg[k], sync_reg[k]};
        end
    end

    assign stat.enc_done     = (i_reg == 8'(SYMBOL_COUNT)) || (j_reg == 8'd255);
    assign stat.last_pending = rem_reg <= 8'(SYMBOLS_PER_GROUP);
    assign stat.out_free     = !ovld_reg || m_tready;

    always_comb
    begin
        msg_next   = msg_reg;
        sreg_next  = sreg_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        data_next  = data_reg;
        sync_next  = sync_reg;
        rem_next   = rem_reg;
        gcnt_next  = gcnt_reg;
        odata_next = odata_reg;
        olast_next = olast_reg;
        ovld_next  = m_tready ? 1'b0 : ovld_reg;

        if (cmd.load)
        begin
            msg_next  = {s_tdata[CALL_W-1:0], s_tdata[CALL_W +: GRID_W]};
            sreg_next = '0;
            j_next    = '0;
            i_next    = '0;
            data_next = '0;
        end

        if (cmd.step)
        begin
            j_next = j_reg + 8'd1;
            if (hit)
            begin
                data_next[rev] = par_bit;
                i_next         = i_reg + 8'd1;
                if (!i_reg[0])
                begin
                    sreg_next = shifted;
                    msg_next  = msg_reg << 1;
                end
            end
        end

        if (cmd.start_emit)
        begin
            for (int k = 0; k < SYMBOL_COUNT; k++)
            begin
                sync_next[k] = SYNC_VEC[k];
            end
            rem_next  = 8'(SYMBOL_COUNT);
            gcnt_next = '0;
        end

        if (cmd.emit)
        begin
            ovld_next  = 1'b1;
            odata_next = {{(OUT_TDATA_W - GIDX_W - SYMS_W - VCNT_W){1'b0}},
                          VCNT_W'(cnt), syms, GIDX_W'(gcnt_reg)};
            olast_next = stat.last_pending;
            // zeros shift in, so slots past the end read as zero
            data_next  = data_reg >> SYMBOLS_PER_GROUP;
            sync_next  = sync_reg >> SYMBOLS_PER_GROUP;
            rem_next   = rem_reg - cnt;
            gcnt_next  = gcnt_reg + GCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
            j_reg    <= '0;
            i_reg    <= '0;
            rem_reg  <= '0;
            gcnt_reg <= '0;
        end
        else
        begin
            ovld_reg <= ovld_next;
            j_reg    <= j_next;
            i_reg    <= i_next;
            rem_reg  <= rem_next;
            gcnt_reg <= gcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg   <= msg_next;
        sreg_reg  <= sreg_next;
        data_reg  <= data_next;
        sync_reg  <= sync_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

endmodule

// ===== sv/wspr_enc_checker.sv =====
module wspr_enc_checker
    import wspr_enc_pkg::*;
#(
    parameter int SYMBOLS_PER_GROUP = 8
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    localparam logic [VCNT_W-1:0] FULL_CNT = VCNT_W'(SYMBOLS_PER_GROUP);

    // held word must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // one message at a time: encoding follows every accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    a_full_groups: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[24:21] == FULL_CNT)
        else $error("short group before the last one");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:25] == '0 && m_tdata[24:21] != '0)
        else $error("bad pad bits or empty group");

endmodule

bind wspr_symbol_encoder wspr_enc_checker #(
    .SYMBOLS_PER_GROUP (SYMBOLS_PER_GROUP)
) u_chk (.*);
